@@ rtl/ird_pkg.sv @@
// Shared constants, types and register indexes for the radix digit expander.
`default_nettype none
package ird_pkg;

    localparam int MAX_DIGITS = 64;
    localparam int DIGIT_BITS = 16;
    localparam int VALUE_W    = 63;
    localparam int RADIX_W    = DIGIT_BITS + 1;
    localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);
    localparam int COL_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RADIX_W;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(1) << DIGIT_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MSB_FIRST   = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_STORE,
        ST_EMIT,
        ST_DRAIN
    } ird_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic store_digit;
        logic emit_read;
    } ird_cmd_t;

    typedef struct packed {
        logic bit_done;
        logic digits_done;
        logic emit_last;
    } ird_status_t;

endpackage
`default_nettype wire

@@ rtl/ird_ctrl.sv @@
// Sequencer: divide, store each digit, then read the row out.
`default_nettype none
module ird_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire ird_pkg::ird_status_t status,
    output ird_pkg::ird_cmd_t        cmd,
    output logic                     busy
);
    import ird_pkg::*;

    ird_state_t state_reg;
    ird_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.bit_done)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store_digit = 1'b1;
                state_next = status.digits_done ? ST_EMIT : ST_DIVIDE;
            end
            ST_EMIT:
            begin
                cmd.emit_read = 1'b1;
                if (status.emit_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last word on the outputs this cycle
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/ird_datapath.sv @@
// Bit-serial divider, digit buffer and readout pipeline.
`default_nettype none
module ird_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ird_pkg::ird_cmd_t                 cmd,
    input  wire logic [ird_pkg::VALUE_W-1:0]       value_in,
    input  wire logic [ird_pkg::RADIX_W-1:0]       radix_eff,
    input  wire logic [ird_pkg::COL_W-1:0]         last_col,
    input  wire logic                              msb_first,
    output ird_pkg::ird_status_t                   status,
    output logic                                   out_valid,
    output logic [ird_pkg::DIGIT_BITS-1:0]         out_digit,
    output logic [ird_pkg::COL_W-1:0]              out_col,
    output logic                                   out_last
);
    import ird_pkg::*;

    logic [VALUE_W-1:0]    quot_reg;
    logic [DIGIT_BITS-1:0] rem_reg;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [COL_W-1:0]      idx_reg;
    logic [COL_W-1:0]      emit_col_reg;

    logic                  out_valid_reg;
    logic [DIGIT_BITS-1:0] out_digit_reg;
    logic [COL_W-1:0]      out_col_reg;
    logic                  out_last_reg;

    logic [DIGIT_BITS-1:0] digit_mem [MAX_DIGITS];

    logic [RADIX_W-1:0]    rem_sh;
    logic [RADIX_W-1:0]    rem_sub;
    logic                  fits;
    logic [DIGIT_BITS-1:0] rem_next;
    logic [VALUE_W-1:0]    quot_next;
    logic [COL_W-1:0]      rd_addr;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_sh    = {rem_reg, quot_reg[VALUE_W-1]};
        rem_sub   = rem_sh - radix_eff;
        fits      = (rem_sh >= radix_eff);
        rem_next  = fits ? rem_sub[DIGIT_BITS-1:0] : rem_sh[DIGIT_BITS-1:0];
        quot_next = {quot_reg[VALUE_W-2:0], fits};
        rd_addr   = msb_first ? (last_col - emit_col_reg) : emit_col_reg;
    end

    assign status.bit_done    = (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1));
    assign status.digits_done = (idx_reg == last_col);
    assign status.emit_last   = (emit_col_reg == last_col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg   <= '0;
            idx_reg       <= '0;
            emit_col_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load || cmd.store_digit)
            begin
                bit_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
            end

            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.store_digit)
            begin
                idx_reg <= idx_reg + COL_W'(1);
            end

            if (cmd.load)
            begin
                emit_col_reg <= '0;
            end
            else if (cmd.emit_read)
            begin
                emit_col_reg <= emit_col_reg + COL_W'(1);
            end

            out_valid_reg <= cmd.emit_read;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quot_reg <= value_in;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
        else if (cmd.store_digit)
        begin
            rem_reg <= '0;
        end

        out_col_reg  <= emit_col_reg;
        out_last_reg <= (emit_col_reg == last_col);
    end

    // digit buffer
    always_ff @(posedge clk)
    begin
        if (cmd.store_digit)
        begin
            digit_mem[idx_reg] <= rem_reg;
        end
        out_digit_reg <= digit_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_digit = out_digit_reg;
    assign out_col   = out_col_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

@@ rtl/integer_to_radix_digits.sv @@
// Radix digit expander top level: configuration registers, sequencer and datapath.
// After start, each of the n digits (n = digit count) is divided out and stored before the first digit word,
// then one digit word per cycle; busy drops the cycle after the last word.
// A new value is taken only when idle, after the last word; all digits come from the
// one-bit-per-cycle restoring divider shared by all digits.
// Reset: asynchronous, active low; registers return to radix 2, 8 digits, LSB first.
// The receiver cannot stall: each word is shown for exactly one cycle.
`default_nettype none
module integer_to_radix_digits (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [ird_pkg::VALUE_W-1:0]          value,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ird_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [ird_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                      digit_valid,
    output logic [ird_pkg::DIGIT_BITS-1:0]            digit,
    output logic [ird_pkg::COL_W-1:0]                 column,
    output logic                                      last
);
    import ird_pkg::*;

    logic [RADIX_W-1:0] radix_reg;
    logic [COUNT_W-1:0] digit_count_reg;
    logic               msb_first_reg;

    logic [RADIX_W-1:0] radix_eff;
    logic [COUNT_W-1:0] count_eff;
    logic [COL_W-1:0]   last_col;

    ird_cmd_t    cmd;
    ird_status_t status;

    // config writes are always taken; the user must write the block only while idle (not enforced)
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= RADIX_W'(2);
            digit_count_reg <= COUNT_W'(8);
            msb_first_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RADIX:       radix_reg       <= cfg_data[RADIX_W-1:0];
                REG_DIGIT_COUNT: digit_count_reg <= cfg_data[COUNT_W-1:0];
                REG_MSB_FIRST:   msb_first_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // clamp radix to 2..2^DIGIT_BITS and count to 1..MAX_DIGITS
    always_comb
    begin
        if (radix_reg < RADIX_MIN)
        begin
            radix_eff = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            radix_eff = RADIX_MAX;
        end
        else
        begin
            radix_eff = radix_reg;
        end

        if (digit_count_reg == '0)
        begin
            count_eff = COUNT_W'(1);
        end
        else if (digit_count_reg > COUNT_W'(MAX_DIGITS))
        begin
            count_eff = COUNT_W'(MAX_DIGITS);
        end
        else
        begin
            count_eff = digit_count_reg;
        end
    end

    // highest column index of the row
    assign last_col = COL_W'(count_eff - COUNT_W'(1));

    ird_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    ird_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value_in  (value),
        .radix_eff (radix_eff),
        .last_col  (last_col),
        .msb_first (msb_first_reg),
        .status    (status),
        .out_valid (digit_valid),
        .out_digit (digit),
        .out_col   (column),
        .out_last  (last)
    );

endmodule
`default_nettype wire
